### sv/dq_pkg.sv
package dq_pkg;

	localparam int DQ_DEPTH = 64;
	localparam int DATA_W   = 32;
	localparam int REQ_W    = 3;
	localparam int ERR_W    = 2;

	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd4;
	localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 3'd5;

	localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
	localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
	localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP_FRONT
	} cell_op_t;

	typedef struct packed {
		cell_op_t                  op;
		logic signed [DATA_W-1:0] value;
	} cell_ctrl_t;

endpackage

### sv/double_ended_queue.sv
// A response beat is registered in the cycle after its request beat is accepted.
// One request per cycle unless stalled; the cells shift or load at most once a beat.
// A back read selects the last occupied cell through an AND-OR over the row.
// Reset (arst_n low) empties the deque and drops any pending response; cell
// contents are not cleared and only cells written by a push are read.
module double_ended_queue import dq_pkg::*; #(
	parameter int DEPTH = DQ_DEPTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic [REQ_W-1:0]                     req_type,
	input  logic signed [DATA_W-1:0]             push_value,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output logic signed [DATA_W-1:0]             read_value,
	output logic [ERR_W-1:0]                     error_code,
	output logic                                 is_empty,
	output logic [$clog2(DEPTH + 1)-1:0]         fill_level
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]            count_q;
	logic                     rsp_valid_q;
	logic signed [DATA_W-1:0] read_value_q;
	logic [ERR_W-1:0]         error_code_q;
	logic                     is_empty_q;
	logic [CW-1:0]            fill_level_q;

	logic                     accept;
	logic                     full;
	logic                     empty;
	cell_ctrl_t               ctrl;
	cell_op_t                 op;
	logic signed [DATA_W-1:0] front_data;
	logic signed [DATA_W-1:0] back_data;
	logic signed [DATA_W-1:0] rd;
	logic [ERR_W-1:0]         err;
	logic [CW-1:0]            count_d;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);

	always_comb begin
		op      = OP_HOLD;
		rd      = '0;
		err     = ERR_NONE;
		count_d = count_q;
		unique case (req_type)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (full) begin
					err = ERR_FULL;
				end else begin
					op      = (req_type == REQ_PUSH_FRONT) ? OP_PUSH_FRONT : OP_PUSH_BACK;
					count_d = count_q + CW'(1);
				end
			end
			REQ_POP_FRONT, REQ_POP_BACK, REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
				if (empty) begin
					err = ERR_EMPTY;
				end else begin
					rd = (req_type == REQ_POP_FRONT || req_type == REQ_PEEK_FRONT) ?
						front_data : back_data;
					if (req_type == REQ_POP_FRONT) begin
						op      = OP_POP_FRONT;
						count_d = count_q - CW'(1);
					end else if (req_type == REQ_POP_BACK) begin
						count_d = count_q - CW'(1);
					end
				end
			end
			default: op = OP_HOLD;
		endcase
	end

	assign ctrl.op    = accept ? op : OP_HOLD;
	assign ctrl.value = push_value;

	dq_chain #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_chain (
		.clk        (clk),
		.ctrl       (ctrl),
		.count      (count_q),
		.front_data (front_data),
		.back_data  (back_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= rd;
			error_code_q <= err;
			is_empty_q   <= (count_d == '0);
			fill_level_q <= count_d;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign read_value = read_value_q;
	assign error_code = error_code_q;
	assign is_empty   = is_empty_q;
	assign fill_level = fill_level_q;

endmodule

### sv/dq_cell.sv
module dq_cell import dq_pkg::*; #(
	parameter int CW  = 7,
	parameter int IDX = 0
) (
	input  logic                     clk,
	input  cell_ctrl_t               ctrl,
	input  logic [CW-1:0]            count,
	input  logic signed [DATA_W-1:0] left_data,
	input  logic signed [DATA_W-1:0] right_data,
	output logic signed [DATA_W-1:0] data,
	output logic                     last
);

	logic signed [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_PUSH_FRONT: data_q <= left_data;
			OP_PUSH_BACK: begin
				if (count == CW'(IDX)) begin
					data_q <= ctrl.value;
				end
			end
			OP_POP_FRONT: data_q <= right_data;
			default: data_q <= data_q;
		endcase
	end

	assign data = data_q;
	assign last = (count == CW'(IDX + 1));

endmodule

### sv/dq_chain.sv
module dq_chain import dq_pkg::*; #(
	parameter int DEPTH = DQ_DEPTH,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                     clk,
	input  cell_ctrl_t               ctrl,
	input  logic [CW-1:0]            count,
	output logic signed [DATA_W-1:0] front_data,
	output logic signed [DATA_W-1:0] back_data
);

	logic signed [DATA_W-1:0] cell_data [DEPTH];
	logic                     cell_last [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_d;
		logic signed [DATA_W-1:0] right_d;

		if (i == 0) begin : g_head
			assign left_d = ctrl.value;
		end else begin : g_body
			assign left_d = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_d = cell_data[i];
		end else begin : g_inner
			assign right_d = cell_data[i+1];
		end

		dq_cell #(
			.CW  (CW),
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.count      (count),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.last       (cell_last[i])
		);
	end

	assign front_data = cell_data[0];

	always_comb begin
		back_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_data = back_data | (cell_last[i] ? cell_data[i] : '0);
		end
	end

endmodule

### sv/dq_checker.sv
module dq_checker import dq_pkg::*; #(
	parameter int DEPTH = DQ_DEPTH
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         rsp_valid,
	input logic                         rsp_stall,
	input logic signed [DATA_W-1:0]     read_value,
	input logic [ERR_W-1:0]             error_code,
	input logic                         is_empty,
	input logic [$clog2(DEPTH + 1)-1:0] fill_level
);

	localparam int CW = $clog2(DEPTH + 1);

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (is_empty == (fill_level == '0)))
		else $error("empty flag disagrees with fill level");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (fill_level <= CW'(DEPTH)))
		else $error("fill level beyond depth");

	a_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && error_code != ERR_NONE |->
			read_value == '0 &&
			((error_code == ERR_EMPTY && fill_level == '0) ||
			 (error_code == ERR_FULL && fill_level == CW'(DEPTH))))
		else $error("refused beat inconsistent with fill level");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(read_value) &&
			$stable(error_code) && $stable(fill_level))
		else $error("stalled response beat changed");

endmodule

bind double_ended_queue dq_checker #(.DEPTH(DEPTH)) u_dq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp_valid),
	.rsp_stall  (rsp_stall),
	.read_value (read_value),
	.error_code (error_code),
	.is_empty   (is_empty),
	.fill_level (fill_level)
);
